// ===== hw/rtl/vls_pkg.sv =====
package vls_pkg;

  // Field widths of the stream payloads.
  localparam int unsigned FuncW    = 3;
  localparam int unsigned InValueW = 32;
  localparam int unsigned InDataW  = 40;
  localparam int unsigned StatusW  = 2;
  localparam int unsigned PosW     = 6;
  localparam int unsigned CountW   = 7;
  localparam int unsigned OutDataW = 16;
  localparam int unsigned OutPadW  = OutDataW - StatusW - PosW - CountW;

  // Width that the input value is sign-extended to before it is cut to the stored width.
  localparam int unsigned ExtW = 64;

  // Parameter defaults.
  localparam int unsigned DefaultCapacity   = 64;
  localparam int unsigned DefaultValueWidth = 32;

  // Operation codes.
  localparam logic [FuncW-1:0] FuncAppend   = 3'd0;
  localparam logic [FuncW-1:0] FuncFind     = 3'd1;
  localparam logic [FuncW-1:0] FuncDelFirst = 3'd2;
  localparam logic [FuncW-1:0] FuncDelAll   = 3'd3;
  localparam logic [FuncW-1:0] FuncClear    = 3'd4;

  // Result status codes.
  localparam logic [StatusW-1:0] StatusOk       = 2'd0;
  localparam logic [StatusW-1:0] StatusNotFound = 2'd1;
  localparam logic [StatusW-1:0] StatusFull     = 2'd2;

  // Per-cycle command to the cell chain.
  typedef struct packed {
    logic shift;
    logic wr_en;
  } chain_ctl_t;

endpackage

// ===== hw/rtl/vls_cell.sv =====
module vls_cell #(
  parameter int unsigned VALUE_WIDTH = vls_pkg::DefaultValueWidth
) (
  input  logic                   clk_i,
  input  logic                   shift_i,
  input  logic [VALUE_WIDTH-1:0] nb_i,
  input  logic                   load_i,
  input  logic [VALUE_WIDTH-1:0] data_i,
  output logic [VALUE_WIDTH-1:0] value_o
);
  import vls_pkg::*;

  logic [VALUE_WIDTH-1:0] value_q;

  // A direct write wins over the shift from the neighbor.
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      value_q <= data_i;
    end else if (shift_i) begin
      value_q <= nb_i;
    end
  end

  assign value_o = value_q;

endmodule

// ===== hw/rtl/vls_chain.sv =====
module vls_chain #(
  parameter int unsigned CAPACITY    = vls_pkg::DefaultCapacity,
  parameter int unsigned VALUE_WIDTH = vls_pkg::DefaultValueWidth,
  parameter int unsigned IDX_W       = (CAPACITY > 1) ? $clog2(CAPACITY) : 1
) (
  input  logic                   clk_i,
  input  vls_pkg::chain_ctl_t    ctl_i,
  input  logic [IDX_W-1:0]       wr_idx_i,
  input  logic [VALUE_WIDTH-1:0] wr_data_i,
  output logic [VALUE_WIDTH-1:0] head_o
);
  import vls_pkg::*;

  logic [VALUE_WIDTH-1:0] cell_val [CAPACITY];

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic                   load;
    logic [VALUE_WIDTH-1:0] nb;

    assign load = ctl_i.wr_en && (wr_idx_i == IDX_W'(i));

    // Every cell takes the value of its upper neighbor on a shift; the top cell holds.
    if (i == CAPACITY - 1) begin : g_top
      assign nb = cell_val[i];
    end else begin : g_mid
      assign nb = cell_val[i+1];
    end

    vls_cell #(
      .VALUE_WIDTH(VALUE_WIDTH)
    ) u_cell (
      .clk_i  (clk_i),
      .shift_i(ctl_i.shift),
      .nb_i   (nb),
      .load_i (load),
      .data_i (wr_data_i),
      .value_o(cell_val[i])
    );
  end

  assign head_o = cell_val[0];

endmodule

// ===== hw/rtl/value_list_store.sv =====
// Append, clear and unused codes give their result from the execute state; find and delete
// first pass the value chain once past its head cell, one step for each value held.
// A new command is taken only when the last one is done, since the single pass of the value
// chain past its head cell keeps the input not ready; find stalls on backpressure.
// Reset: count, state and output valid clear at once; the value cells are not reset.
module value_list_store #(
  parameter int unsigned CAPACITY    = vls_pkg::DefaultCapacity,
  parameter int unsigned VALUE_WIDTH = vls_pkg::DefaultValueWidth
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         s_axis_tvalid_i,
  output logic                         s_axis_tready_o,
  // func [2:0], value [34:3], zero [39:35]
  input  logic [vls_pkg::InDataW-1:0]  s_axis_tdata_i,
  output logic                         m_axis_tvalid_o,
  input  logic                         m_axis_tready_i,
  // status [1:0], position [7:2], entry_count [14:8], zero [15]
  output logic [vls_pkg::OutDataW-1:0] m_axis_tdata_o,
  output logic                         m_axis_tlast_o
);
  import vls_pkg::*;

  localparam int unsigned IdxW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CntW = $clog2(CAPACITY + 1);

  localparam logic StIdle = 1'b0;
  localparam logic StExec = 1'b1;

  // The list lives in a chain of cells with the first entry in cell 0. Find and delete
  // run the chain as a queue: each step pops the head, shifts every cell down by one and,
  // when the head is kept, writes it back just above the queued entries. After n steps
  // the kept entries sit in order from cell 0 upward, so delete compacts in one pass and
  // find leaves the list as it was.

  logic                   state_q, state_d;
  logic [FuncW-1:0]       func_q, func_d;
  logic [VALUE_WIDTH-1:0] val_q, val_d;
  logic [CntW-1:0]        cnt_q, cnt_d;
  logic [CntW-1:0]        occ_q, occ_d;
  logic [CntW-1:0]        pos_q, pos_d;
  logic                   hit_q, hit_d;
  logic                   pend_q, pend_d;
  logic [IdxW-1:0]        pend_pos_q, pend_pos_d;

  logic                   m_valid_q;
  logic [OutDataW-1:0]    m_data_q;
  logic                   m_last_q;

  logic                   accept;
  logic                   out_free;
  logic [InValueW-1:0]    in_value;
  logic [ExtW-1:0]        in_ext;
  logic [VALUE_WIDTH-1:0] head_val;
  logic                   match;
  logic                   is_find;
  logic                   is_del;
  logic                   scanning;
  logic                   keep;
  logic                   emit_need;
  logic [CntW-1:0]        occ_m1;

  chain_ctl_t             chain_ctl;
  logic [IdxW-1:0]        wr_idx;
  logic [VALUE_WIDTH-1:0] wr_data;

  logic                   emit;
  logic [StatusW-1:0]     res_status;
  logic [IdxW-1:0]        res_pos;
  logic [CntW-1:0]        res_count;
  logic                   res_last;

  assign s_axis_tready_o = (state_q == StIdle);
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;
  assign out_free        = !m_valid_q || m_axis_tready_i;

  // The value is sign-extended and then kept as its low VALUE_WIDTH bits.
  assign in_value = s_axis_tdata_i[FuncW +: InValueW];
  assign in_ext   = {{(ExtW - InValueW){in_value[InValueW-1]}}, in_value};

  assign match    = (head_val == val_q);
  assign is_find  = (func_q == FuncFind);
  assign is_del   = (func_q == FuncDelFirst) || (func_q == FuncDelAll);
  assign scanning = (is_find || is_del) && (pos_q != cnt_q);
  assign occ_m1   = occ_q - CntW'(1);

  // Delete-first drops only its first match and delete-all every match; find keeps all entries.
  assign keep = is_find || !match || ((func_q == FuncDelFirst) && hit_q);

  // A find match is held back until the next match or the end of the pass, so the final
  // one can carry the last flag. Passing on a held match needs the output register.
  assign emit_need = is_find && match && pend_q;

  always_comb begin
    state_d    = state_q;
    func_d     = func_q;
    val_d      = val_q;
    cnt_d      = cnt_q;
    occ_d      = occ_q;
    pos_d      = pos_q;
    hit_d      = hit_q;
    pend_d     = pend_q;
    pend_pos_d = pend_pos_q;
    chain_ctl  = '0;
    wr_idx     = occ_m1[IdxW-1:0];
    wr_data    = head_val;
    emit       = 1'b0;
    res_status = StatusOk;
    res_pos    = '0;
    res_count  = cnt_q;
    res_last   = 1'b1;

    case (state_q)
      StIdle: begin
        if (accept) begin
          func_d  = s_axis_tdata_i[FuncW-1:0];
          val_d   = in_ext[VALUE_WIDTH-1:0];
          pos_d   = '0;
          occ_d   = cnt_q;
          hit_d   = 1'b0;
          pend_d  = 1'b0;
          state_d = StExec;
        end
      end
      StExec: begin
        if (scanning) begin
          if (!emit_need || out_free) begin
            chain_ctl.shift = 1'b1;
            chain_ctl.wr_en = keep;
            pos_d           = pos_q + CntW'(1);
            if (!keep) begin
              occ_d = occ_m1;
              hit_d = 1'b1;
            end
            if (is_find && match) begin
              pend_d     = 1'b1;
              pend_pos_d = pos_q[IdxW-1:0];
              emit       = emit_need;
              res_pos    = pend_pos_q;
              res_last   = 1'b0;
            end
          end
        end else if (out_free) begin
          emit    = 1'b1;
          state_d = StIdle;
          case (func_q)
            FuncAppend: begin
              if (cnt_q == CntW'(CAPACITY)) begin
                res_status = StatusFull;
              end else begin
                chain_ctl.wr_en = 1'b1;
                wr_idx          = cnt_q[IdxW-1:0];
                wr_data         = val_q;
                cnt_d           = cnt_q + CntW'(1);
                res_count       = cnt_q + CntW'(1);
              end
            end
            FuncFind: begin
              if (pend_q) begin
                res_pos = pend_pos_q;
              end else begin
                res_status = StatusNotFound;
              end
            end
            FuncDelFirst, FuncDelAll: begin
              res_status = hit_q ? StatusOk : StatusNotFound;
              cnt_d      = occ_q;
              res_count  = occ_q;
            end
            FuncClear: begin
              cnt_d     = '0;
              res_count = '0;
            end
            default: begin
              // Unused codes change nothing and report done.
            end
          endcase
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= StIdle;
      cnt_q     <= '0;
      occ_q     <= '0;
      pos_q     <= '0;
      hit_q     <= 1'b0;
      pend_q    <= 1'b0;
      m_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      occ_q   <= occ_d;
      pos_q   <= pos_d;
      hit_q   <= hit_d;
      pend_q  <= pend_d;
      if (emit) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers need no reset.
  always_ff @(posedge clk_i) begin
    func_q     <= func_d;
    val_q      <= val_d;
    pend_pos_q <= pend_pos_d;
    if (emit) begin
      m_data_q <= {{OutPadW{1'b0}}, CountW'(res_count), PosW'(res_pos), res_status};
      m_last_q <= res_last;
    end
  end

  vls_chain #(
    .CAPACITY   (CAPACITY),
    .VALUE_WIDTH(VALUE_WIDTH),
    .IDX_W      (IdxW)
  ) u_chain (
    .clk_i    (clk_i),
    .ctl_i    (chain_ctl),
    .wr_idx_i (wr_idx),
    .wr_data_i(wr_data),
    .head_o   (head_val)
  );

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = m_data_q;
  assign m_axis_tlast_o  = m_last_q;

endmodule
